// File: rtl/ddct_pkg.sv
// ----------------------------------------------------------------------------
// ddct_pkg
// Shared types and constants for the dual down-counting timer.
// ----------------------------------------------------------------------------
package ddct_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int COUNT_WIDTH  = 32;
  localparam int DATA_WIDTH   = 32;
  localparam int PRE_WIDTH    = 3;
  localparam int PSC_WIDTH    = 7;

  // request opcodes
  typedef enum logic [1:0] {
    OP_FAST_TICK = 2'd0,
    OP_SLOW_TICK = 2'd1,
    OP_BUS_READ  = 2'd2,
    OP_BUS_WRITE = 2'd3
  } opcode_t;

  // global word offsets (byte offset bits 5:2)
  localparam logic [3:0] WORD_IRQ_EN   = 4'h0;
  localparam logic [3:0] WORD_IRQ_STAT = 4'h1;

  // per-channel register select (byte offset bits 3:2)
  localparam logic [1:0] CH_REG_CTRL = 2'd0;
  localparam logic [1:0] CH_REG_INTV = 2'd1;
  localparam logic [1:0] CH_REG_CNT  = 2'd2;

  // control register bus bit positions
  localparam int CTRL_RUN_BIT    = 0;
  localparam int CTRL_RELOAD_BIT = 1;
  localparam int CTRL_FAST_BIT   = 2;
  localparam int CTRL_PRE_LSB    = 4;
  localparam int CTRL_SINGLE_BIT = 7;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [5:0]            byte_offset;
    logic [DATA_WIDTH-1:0] write_value;
  } in_req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_value;
    logic [1:0]            irq_lines;
  } out_rsp_t;

  // command from the decoder to one channel
  typedef struct packed {
    logic                  tick_en;
    logic                  tick_fast;
    logic                  wr_ctrl;
    logic                  wr_intv;
    logic                  wr_cnt;
    logic [DATA_WIDTH-1:0] wdata;
  } ch_cmd_t;

  // channel state seen by the decoder
  typedef struct packed {
    logic [7:0]             ctrl_bus;
    logic [COUNT_WIDTH-1:0] interval;
    logic [COUNT_WIDTH-1:0] count;
    logic                   expire;
  } ch_stat_t;

endpackage

// File: rtl/ddct_channel.sv
// ----------------------------------------------------------------------------
// ddct_channel
// One timer channel: control, interval, count and prescaler with expiry.
// ----------------------------------------------------------------------------
module ddct_channel (
  input  logic              clk,
  input  logic              rst_n,
  input  ddct_pkg::ch_cmd_t cmd,
  output ddct_pkg::ch_stat_t stat
);
  import ddct_pkg::*;

  logic                   run_r, run_nxt;
  logic                   fast_r, fast_nxt;
  logic                   single_r, single_nxt;
  logic [PRE_WIDTH-1:0]   pre_r, pre_nxt;
  logic [COUNT_WIDTH-1:0] intv_r, intv_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [PSC_WIDTH-1:0]   psc_r, psc_nxt;

  logic                   tick_hit;
  logic [PSC_WIDTH:0]     psc_inc;
  logic [PSC_WIDTH:0]     period;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic                   expire;

  assign tick_hit = cmd.tick_en && run_r && (fast_r == cmd.tick_fast);
  assign psc_inc  = {1'b0, psc_r} + (PSC_WIDTH+1)'(1);
  assign period   = (PSC_WIDTH+1)'(1) << pre_r;
  // counting from zero expires at once
  assign cnt_dec  = (cnt_r != '0) ? cnt_r - COUNT_WIDTH'(1) : '0;

  always_comb begin
    run_nxt    = run_r;
    fast_nxt   = fast_r;
    single_nxt = single_r;
    pre_nxt    = pre_r;
    intv_nxt   = intv_r;
    cnt_nxt    = cnt_r;
    psc_nxt    = psc_r;
    expire     = 1'b0;
    if (tick_hit) begin
      if (psc_inc >= period) begin
        psc_nxt = '0;
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          expire = 1'b1;
          if (single_r) run_nxt = 1'b0;
          else          cnt_nxt = intv_r;
        end
      end else begin
        psc_nxt = psc_inc[PSC_WIDTH-1:0];
      end
    end
    if (cmd.wr_ctrl) begin
      run_nxt    = cmd.wdata[CTRL_RUN_BIT];
      fast_nxt   = cmd.wdata[CTRL_FAST_BIT];
      pre_nxt    = cmd.wdata[CTRL_PRE_LSB +: PRE_WIDTH];
      single_nxt = cmd.wdata[CTRL_SINGLE_BIT];
      if (cmd.wdata[CTRL_RELOAD_BIT]) begin
        cnt_nxt = intv_r;
        psc_nxt = '0;
      end
    end
    if (cmd.wr_intv) intv_nxt = cmd.wdata[COUNT_WIDTH-1:0];
    if (cmd.wr_cnt)  cnt_nxt  = cmd.wdata[COUNT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      fast_r   <= 1'b0;
      single_r <= 1'b0;
      pre_r    <= '0;
      intv_r   <= '0;
      cnt_r    <= '0;
      psc_r    <= '0;
    end else begin
      run_r    <= run_nxt;
      fast_r   <= fast_nxt;
      single_r <= single_nxt;
      pre_r    <= pre_nxt;
      intv_r   <= intv_nxt;
      cnt_r    <= cnt_nxt;
      psc_r    <= psc_nxt;
    end
  end

  assign stat.ctrl_bus = {single_r, pre_r, 1'b0, fast_r, 1'b0, run_r};
  assign stat.interval = intv_r;
  assign stat.count    = cnt_r;
  assign stat.expire   = expire;

endmodule

// File: rtl/dual_down_counter_timer_top.sv
// ----------------------------------------------------------------------------
// dual_down_counter_timer_top
// Two-channel register-mapped down-counting timer with prescaler.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | moves
//  --------+--------------------------------+----------------------------------
//  input   | in_valid, in_stall, in_req     | tick or bus read/write request
//  result  | out_valid, out_stall, out_rsp  | read data and irq lines, one per
//          |                                | request
//
//  Throughput is one request per clock while the result is not stalled; a
//  request passes the input register, then the result register. The decode,
//  the channel update and the read mux all sit between those two registers.
//  Reset (rst_n low, synchronous) clears all timer state and both valids.
//  A stalled result holds the result register; the input register keeps
//  taking requests while it is empty or draining into the result register.
//
module dual_down_counter_timer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ddct_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output ddct_pkg::out_rsp_t out_rsp
);
  import ddct_pkg::*;

  // input register
  logic    req_valid_r;
  in_req_t req_r;

  // result register
  logic     rsp_valid_r;
  out_rsp_t rsp_r;

  // interrupt registers
  logic [NUM_CHANNELS-1:0] irq_en_r, irq_en_nxt;
  logic [NUM_CHANNELS-1:0] irq_stat_r, irq_stat_nxt;

  logic     advance;     // request in input register moves to result
  logic     is_tick, is_read, is_write;
  logic [3:0] word;
  logic [1:0] blk;
  logic [1:0] creg;

  ch_cmd_t  ch_cmd  [NUM_CHANNELS];
  ch_stat_t ch_stat [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] expire;
  logic [DATA_WIDTH-1:0]   rd_data;
  out_rsp_t                rsp_nxt;

  assign advance  = req_valid_r && (!rsp_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;

  assign is_tick  = advance && (req_r.opcode == OP_FAST_TICK ||
                                req_r.opcode == OP_SLOW_TICK);
  assign is_read  = advance && (req_r.opcode == OP_BUS_READ);
  assign is_write = advance && (req_r.opcode == OP_BUS_WRITE);

  // word address; blk 1..N selects a channel, creg the register within it
  assign word = req_r.byte_offset[5:2];
  assign blk  = req_r.byte_offset[5:4];
  assign creg = req_r.byte_offset[3:2];

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
    logic hit;
    assign hit = (blk == 2'(c + 1));

    assign ch_cmd[c].tick_en   = is_tick;
    assign ch_cmd[c].tick_fast = (req_r.opcode == OP_FAST_TICK);
    assign ch_cmd[c].wr_ctrl   = is_write && hit && (creg == CH_REG_CTRL);
    assign ch_cmd[c].wr_intv   = is_write && hit && (creg == CH_REG_INTV);
    assign ch_cmd[c].wr_cnt    = is_write && hit && (creg == CH_REG_CNT);
    assign ch_cmd[c].wdata     = req_r.write_value;

    ddct_channel u_channel (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (ch_cmd[c]),
      .stat (ch_stat[c])
    );

    assign expire[c] = ch_stat[c].expire;
  end

  // interrupt enable/status; write-1-to-clear on status
  always_comb begin
    irq_en_nxt   = irq_en_r;
    irq_stat_nxt = irq_stat_r | expire;
    if (is_write && word == WORD_IRQ_EN)
      irq_en_nxt = req_r.write_value[NUM_CHANNELS-1:0];
    if (is_write && word == WORD_IRQ_STAT)
      irq_stat_nxt = irq_stat_r & ~req_r.write_value[NUM_CHANNELS-1:0];
  end

  // read mux; unmapped offsets read zero
  always_comb begin
    rd_data = '0;
    if (is_read) begin
      if (word == WORD_IRQ_EN) begin
        rd_data = DATA_WIDTH'(irq_en_r);
      end else if (word == WORD_IRQ_STAT) begin
        rd_data = DATA_WIDTH'(irq_stat_r);
      end else begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (blk == 2'(c + 1)) begin
            unique case (creg)
              CH_REG_CTRL: rd_data = DATA_WIDTH'(ch_stat[c].ctrl_bus);
              CH_REG_INTV: rd_data = DATA_WIDTH'(ch_stat[c].interval);
              CH_REG_CNT:  rd_data = DATA_WIDTH'(ch_stat[c].count);
              default:     rd_data = '0;
            endcase
          end
        end
      end
    end
  end

  assign rsp_nxt.read_value = rd_data;
  assign rsp_nxt.irq_lines  = 2'(irq_stat_nxt & irq_en_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      rsp_valid_r <= 1'b0;
      irq_en_r    <= '0;
      irq_stat_r  <= '0;
    end else begin
      if (in_valid && !in_stall)
        req_valid_r <= 1'b1;
      else if (advance)
        req_valid_r <= 1'b0;

      if (advance)
        rsp_valid_r <= 1'b1;
      else if (!out_stall)
        rsp_valid_r <= 1'b0;

      irq_en_r   <= irq_en_nxt;
      irq_stat_r <= irq_stat_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) req_r <= in_req;
    if (advance)               rsp_r <= rsp_nxt;
  end

  assign out_valid = rsp_valid_r;
  assign out_rsp   = rsp_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a held request stays in the input register
  a_req_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && !advance) |=> req_valid_r)
    else $error("input request dropped while blocked");

  // only reads return data
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && req_r.opcode != OP_BUS_READ) |=> (rsp_r.read_value == '0))
    else $error("nonzero read data on non-read request");

  // status bits only get set by a tick
  a_stat_set: assert property (@(posedge clk) disable iff (!rst_n)
    !is_tick |=> ((irq_stat_r & ~$past(irq_stat_r)) == '0))
    else $error("irq status set without a tick");

  // the input side never takes a request while the pipe is blocked
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && rsp_valid_r && out_stall) |-> in_stall)
    else $error("request accepted while blocked");

endmodule
